// ===== design/c8u_pkg.sv =====
// Package for the single-byte Cyrillic to UTF-8 converter.
// Holds encoding codes, mapping constants, the KOI8-R table and shared types.
// No dependencies.
package c8u_pkg;

  // Source encoding codes held in the configuration register.
  localparam logic [1:0] ENC_CP1251 = 2'd0;
  localparam logic [1:0] ENC_KOI8R  = 2'd1;
  localparam logic [1:0] ENC_ISO    = 2'd2;

  // Register map.
  localparam int unsigned PADDR_W   = 3;
  localparam logic        REG_SRC_ENC = 1'b0;

  // Mapping constants.
  localparam logic [7:0]  START_CODE       = 8'hB0;
  localparam logic [7:0]  KOI8R_TABLE_BASE = 8'hC0;
  localparam int unsigned CP_W             = 11;
  localparam logic [CP_W-1:0] CP1251_OFFSET = 11'h350;
  localparam logic [CP_W-1:0] ISO_OFFSET    = 11'h360;

  // One converted character handed to the output serializer.
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] trail;
    logic       two;
  } pair_t;

  // KOI8-R code points for bytes 0xC0 to 0xFF.
  function automatic logic [CP_W-1:0] koi8r_cp(input logic [5:0] idx);
    logic [CP_W-1:0] cp;
    case (idx)
      6'd0:  cp = 11'h44E;  6'd1:  cp = 11'h430;  6'd2:  cp = 11'h431;  6'd3:  cp = 11'h446;
      6'd4:  cp = 11'h434;  6'd5:  cp = 11'h435;  6'd6:  cp = 11'h444;  6'd7:  cp = 11'h433;
      6'd8:  cp = 11'h445;  6'd9:  cp = 11'h438;  6'd10: cp = 11'h439;  6'd11: cp = 11'h43A;
      6'd12: cp = 11'h43B;  6'd13: cp = 11'h43C;  6'd14: cp = 11'h43D;  6'd15: cp = 11'h43E;
      6'd16: cp = 11'h43F;  6'd17: cp = 11'h44F;  6'd18: cp = 11'h440;  6'd19: cp = 11'h441;
      6'd20: cp = 11'h442;  6'd21: cp = 11'h443;  6'd22: cp = 11'h436;  6'd23: cp = 11'h432;
      6'd24: cp = 11'h44C;  6'd25: cp = 11'h44B;  6'd26: cp = 11'h437;  6'd27: cp = 11'h448;
      6'd28: cp = 11'h44D;  6'd29: cp = 11'h449;  6'd30: cp = 11'h447;  6'd31: cp = 11'h44A;
      6'd32: cp = 11'h42E;  6'd33: cp = 11'h410;  6'd34: cp = 11'h411;  6'd35: cp = 11'h426;
      6'd36: cp = 11'h414;  6'd37: cp = 11'h415;  6'd38: cp = 11'h424;  6'd39: cp = 11'h413;
      6'd40: cp = 11'h425;  6'd41: cp = 11'h418;  6'd42: cp = 11'h419;  6'd43: cp = 11'h41A;
      6'd44: cp = 11'h41B;  6'd45: cp = 11'h41C;  6'd46: cp = 11'h41D;  6'd47: cp = 11'h41E;
      6'd48: cp = 11'h41F;  6'd49: cp = 11'h42F;  6'd50: cp = 11'h420;  6'd51: cp = 11'h421;
      6'd52: cp = 11'h422;  6'd53: cp = 11'h423;  6'd54: cp = 11'h416;  6'd55: cp = 11'h412;
      6'd56: cp = 11'h42C;  6'd57: cp = 11'h42B;  6'd58: cp = 11'h417;  6'd59: cp = 11'h428;
      6'd60: cp = 11'h42D;  6'd61: cp = 11'h429;  6'd62: cp = 11'h427;  6'd63: cp = 11'h42A;
      default: cp = 11'h000;
    endcase
    return cp;
  endfunction

endpackage

// ===== design/c8u_serializer.sv =====
// Output stage of the converter: emits one or two UTF-8 bytes per character.
// Depends on c8u_pkg for pair_t.
module c8u_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  c8u_pkg::pair_t item,
  output logic           item_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_last_of_run
);

  logic       out_valid_r;
  logic       out_last_r;
  logic [7:0] out_byte_r;
  logic [7:0] trail_r;
  logic       lead_done;

  // The lead byte of a pair has left; the trail byte follows next.
  assign lead_done  = out_valid_r && !out_stall && !out_last_r;
  // A new character may load once the last byte of the current one leaves.
  assign item_ready = !out_valid_r || (!out_stall && out_last_r);

  // Control state of the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (lead_done) begin
      out_last_r <= 1'b1;
    end else if (item_ready) begin
      out_valid_r <= item_valid;
      if (item_valid) begin
        out_last_r <= !item.two;
      end
    end
  end

  // Payload of the output register and the held trail byte.
  always_ff @(posedge clk) begin
    if (lead_done) begin
      out_byte_r <= trail_r;
    end else if (item_ready && item_valid) begin
      out_byte_r <= item.lead;
      trail_r    <= item.trail;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

// ===== design/cyrillic_8bit_to_utf8_unit.sv =====
// Top level of the single-byte Cyrillic (CP1251, KOI8-R, ISO-8859-5) to UTF-8 converter.
// Depends on c8u_pkg and c8u_serializer.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   in_byte[7:0]
//   out_     output     out_valid / out_stall out_byte[7:0], out_last_of_run
//   cfg      input      APB psel/penable      source_encoding at address 0
//
// A byte enters every cycle while no stall backs up; its first output byte passes
// stages 1, 2 and 3 and the serializer's output register in turn. The one-byte
// output register sets the rate: it sends one byte per transfer, so a two-byte
// sequence holds the next character back until its trail byte has left.
// Reset (rst_n, synchronous) empties the pipeline and selects CP1251.
// A stall holds each full stage with only full stages between it and the output; the rest still move up.
module cyrillic_8bit_to_utf8_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [c8u_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [1:0]  enc_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [1:0]  s1_enc_r;

  logic        s2_valid_r;
  logic [7:0]  s2_byte_r;
  logic        s2_map_r;
  logic [c8u_pkg::CP_W-1:0] s2_cp_r;
  logic        s2_map_nxt;
  logic [c8u_pkg::CP_W-1:0] s2_cp_nxt;

  logic           s3_valid_r;
  c8u_pkg::pair_t s3_item_r;
  c8u_pkg::pair_t s3_item_nxt;

  logic rdy1, rdy2, rdy3, ser_ready;

  // Configuration register; a write transfer completes in the access cycle.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r <= c8u_pkg::ENC_CP1251;
    end else if (psel && penable && pwrite && (paddr[2] == c8u_pkg::REG_SRC_ENC)) begin
      enc_r <= pwdata[1:0];
    end
  end
  assign prdata = (paddr[2] == c8u_pkg::REG_SRC_ENC) ? {30'd0, enc_r} : 32'd0;

  // Each stage loads when it is empty or its content moves on.
  assign rdy3     = !s3_valid_r || ser_ready;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign in_stall = !rdy1;

  // Stage 1: capture the byte with the encoding in force.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (rdy1) begin
      s1_valid_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_byte_r <= in_byte;
      s1_enc_r  <= enc_r;
    end
  end

  // Stage 2: decide whether the byte maps and find its code point.
  always_comb begin
    s2_map_nxt = 1'b0;
    s2_cp_nxt  = '0;
    case (s1_enc_r)
      c8u_pkg::ENC_CP1251: begin
        s2_map_nxt = (s1_byte_r >= c8u_pkg::START_CODE);
        s2_cp_nxt  = {3'd0, s1_byte_r} + c8u_pkg::CP1251_OFFSET;
      end
      c8u_pkg::ENC_KOI8R: begin
        s2_map_nxt = (s1_byte_r >= c8u_pkg::KOI8R_TABLE_BASE);
        s2_cp_nxt  = c8u_pkg::koi8r_cp(s1_byte_r[5:0]);
      end
      c8u_pkg::ENC_ISO: begin
        s2_map_nxt = (s1_byte_r >= c8u_pkg::START_CODE);
        s2_cp_nxt  = {3'd0, s1_byte_r} + c8u_pkg::ISO_OFFSET;
      end
      default: begin
        s2_map_nxt = 1'b0;
        s2_cp_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (rdy2) begin
      s2_valid_r <= s1_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_r) begin
      s2_byte_r <= s1_byte_r;
      s2_map_r  <= s2_map_nxt;
      s2_cp_r   <= s2_cp_nxt;
    end
  end

  // Stage 3: build the UTF-8 lead and trail bytes, or pass the byte through.
  always_comb begin
    s3_item_nxt.two   = s2_map_r;
    s3_item_nxt.lead  = s2_map_r ? {3'b110, s2_cp_r[10:6]} : s2_byte_r;
    s3_item_nxt.trail = {2'b10, s2_cp_r[5:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (rdy3) begin
      s3_valid_r <= s2_valid_r;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy3 && s2_valid_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  // Output stage: one byte per transfer.
  c8u_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (s3_valid_r),
    .item            (s3_item_r),
    .item_ready      (ser_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
